@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DV64_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DV64_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dv64_pkg.sv @@
// ----------------------------------------------------------------------------
// dv64_pkg
// Types and constants shared by the 64-bit divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

package dv64_pkg;

    localparam int unsigned DW        = 64;
    localparam int unsigned NUM_STEPS = 64;

    localparam logic [DW-1:0] MIN_S64  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] NEG_ONE  = {DW{1'b1}};

    typedef enum logic [1:0] {
        MODE_UQUO = 2'd0,
        MODE_UREM = 2'd1,
        MODE_SQUO = 2'd2,
        MODE_SREM = 2'd3
    } dv64_mode_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_OVERFLOW = 2'd2
    } dv64_err_t;

    // sideband that rides along with each beat
    typedef struct packed {
        logic      rem_sel;
        logic      neg_res;
        dv64_err_t err;
    } dv64_side_t;

    // working word of one cell: partial remainder, dividend/quotient shifter, divisor, sideband
    typedef struct packed {
        logic [DW-1:0] part;
        logic [DW-1:0] numq;
        logic [DW-1:0] den;
        dv64_side_t    side;
    } dv64_lane_t;

endpackage

`default_nettype wire

@@ sv/dv64_prep.sv @@
// ----------------------------------------------------------------------------
// dv64_prep
// Entry stage: fault checks, operand magnitudes and result sign.
// ----------------------------------------------------------------------------
`default_nettype none

module dv64_prep (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    adv,
    input  wire logic                    valid_i,
    input  wire logic [63:0]             dividend,
    input  wire logic [63:0]             divisor,
    input  wire logic [1:0]              mode,
    output logic                         valid_o,
    output dv64_pkg::dv64_lane_t         lane_o
);
    import dv64_pkg::*;

    logic       valid_reg;
    dv64_lane_t lane_reg;
    dv64_lane_t lane_next;
    dv64_mode_t mode_op;
    logic       signed_op;
    logic       num_neg;
    logic       den_neg;

    always_comb begin
        mode_op   = dv64_mode_t'(mode);
        signed_op = (mode_op == MODE_SQUO) || (mode_op == MODE_SREM);
        num_neg   = signed_op & dividend[DW-1];
        den_neg   = signed_op & divisor[DW-1];

        lane_next.part = '0;
        lane_next.numq = num_neg ? (~dividend + 1'b1) : dividend;
        lane_next.den  = den_neg ? (~divisor + 1'b1) : divisor;

        lane_next.side.rem_sel = (mode_op == MODE_UREM) || (mode_op == MODE_SREM);
        // quotient sign from both operands, remainder sign from the dividend
        lane_next.side.neg_res = (mode_op == MODE_SREM) ? num_neg : (num_neg ^ den_neg);

        if (divisor == '0) begin
            lane_next.side.err = ERR_DIV_ZERO;
        end else if (mode_op == MODE_SQUO && dividend == MIN_S64 && divisor == NEG_ONE) begin
            lane_next.side.err = ERR_OVERFLOW;
        end else begin
            lane_next.side.err = ERR_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lane_reg <= lane_next;
        end
    end

    assign valid_o = valid_reg;
    assign lane_o  = lane_reg;

endmodule

`default_nettype wire

@@ sv/dv64_cell.sv @@
// ----------------------------------------------------------------------------
// dv64_cell
// One restoring step: shift in a dividend bit, trial subtract, keep a bit.
// ----------------------------------------------------------------------------
`default_nettype none

module dv64_cell (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    adv,
    input  wire logic                    valid_i,
    input  wire dv64_pkg::dv64_lane_t    lane_i,
    output logic                         valid_o,
    output dv64_pkg::dv64_lane_t         lane_o
);
    import dv64_pkg::*;

    logic          valid_reg;
    dv64_lane_t    lane_reg;
    dv64_lane_t    lane_next;
    logic [DW-1:0] shifted;
    logic [DW:0]   diff;
    logic          fit;

    always_comb begin
        // partial remainder never reaches 2^63 before its last shift
        shifted = {lane_i.part[DW-2:0], lane_i.numq[DW-1]};
        diff    = {1'b0, shifted} - {1'b0, lane_i.den};
        fit     = ~diff[DW];

        lane_next.part = fit ? diff[DW-1:0] : shifted;
        lane_next.numq = {lane_i.numq[DW-2:0], fit};
        lane_next.den  = lane_i.den;
        lane_next.side = lane_i.side;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lane_reg <= lane_next;
        end
    end

    assign valid_o = valid_reg;
    assign lane_o  = lane_reg;

endmodule

`default_nettype wire

@@ sv/dv64_post.sv @@
// ----------------------------------------------------------------------------
// dv64_post
// Exit stage: pick quotient or remainder, apply sign, zero on fault.
// ----------------------------------------------------------------------------
`default_nettype none

module dv64_post (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    adv,
    input  wire logic                    valid_i,
    input  wire dv64_pkg::dv64_lane_t    lane_i,
    output logic                         valid_o,
    output logic [63:0]                  result,
    output logic [1:0]                   error
);
    import dv64_pkg::*;

    logic          valid_reg;
    logic [DW-1:0] result_reg;
    logic [DW-1:0] result_next;
    dv64_err_t     error_reg;
    logic [DW-1:0] value;

    always_comb begin
        value = lane_i.side.rem_sel ? lane_i.part : lane_i.numq;
        if (lane_i.side.err != ERR_OK) begin
            result_next = '0;
        end else if (lane_i.side.neg_res) begin
            result_next = ~value + 1'b1;
        end else begin
            result_next = value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            result_reg <= result_next;
            error_reg  <= lane_i.side.err;
        end
    end

    assign valid_o = valid_reg;
    assign result  = result_reg;
    assign error   = error_reg;

endmodule

`default_nettype wire

@@ sv/divide_64bit_signed_unsigned.sv @@
// Pipelined 64-bit divider, unsigned or signed, quotient or remainder. It takes one beat
// per cycle and passes each result through its registered stages: one entry stage
// for fault checks and magnitudes, a row of 64 cells that each perform one restoring
// compare-subtract on a 64-bit partial remainder, and one exit stage that applies the
// sign and registers the result. A held output beat stalls the whole row, so throughput
// stays one beat per cycle whenever the output side is ready. A zero divisor gives
// error 1, the signed quotient of the minimum value by -1 gives error 2, and the result
// is zero in both cases.
// ----------------------------------------------------------------------------
// divide_64bit_signed_unsigned
// Top level: stream ports, entry stage, divider cell row, exit stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module divide_64bit_signed_unsigned (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [127:0]  s_tdata,   // [63:0] dividend, [127:64] divisor
    input  wire logic [1:0]    s_tuser,   // [1:0] mode
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata,   // [63:0] result
    output logic [1:0]         m_tuser    // [1:0] error
);
    import dv64_pkg::*;

    logic       adv;
    logic       valid_w [NUM_STEPS+1];
    dv64_lane_t lane_w  [NUM_STEPS+1];

    // advance every stage unless the output beat is held
    assign adv      = ~m_tvalid | m_tready;
    assign s_tready = adv;

    dv64_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .valid_i  (s_tvalid),
        .dividend (s_tdata[DW-1:0]),
        .divisor  (s_tdata[2*DW-1:DW]),
        .mode     (s_tuser),
        .valid_o  (valid_w[0]),
        .lane_o   (lane_w[0])
    );

    for (genvar i = 0; i < NUM_STEPS; i++) begin : g_cell
        dv64_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .valid_i (valid_w[i]),
            .lane_i  (lane_w[i]),
            .valid_o (valid_w[i+1]),
            .lane_o  (lane_w[i+1])
        );
    end

    dv64_post u_post (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .valid_i (valid_w[NUM_STEPS]),
        .lane_i  (lane_w[NUM_STEPS]),
        .valid_o (m_tvalid),
        .result  (m_tdata),
        .error   (m_tuser)
    );

    `DV64_ASSERT_NXT(a_zero_div_flagged, s_tvalid && s_tready && s_tdata[127:64] == 64'd0, valid_w[0] && lane_w[0].side.err == ERR_DIV_ZERO, "zero divisor not flagged at entry")
    `DV64_ASSERT_IMP(a_rem_below_den, valid_w[NUM_STEPS] && lane_w[NUM_STEPS].den != '0, lane_w[NUM_STEPS].part < lane_w[NUM_STEPS].den, "final remainder not below divisor")
    `DV64_ASSERT_IMP(a_fault_zero_result, m_tvalid && m_tuser != ERR_OK, m_tdata == 64'd0, "nonzero result on fault")

endmodule

`default_nettype wire

@@ verif/tb_divide_64bit_signed_unsigned.sv @@
// ----------------------------------------------------------------------------
// tb_divide_64bit_signed_unsigned
// Self-checking bench for the pipelined 64-bit divider. A directed set covers
// zero divisors, the signed overflow case, the minimum value and sign mixes.
// Random operands of mixed shapes follow. The input stream runs in bursts and
// the output side stalls on its own pattern. Every result beat is checked
// against a native-arithmetic model of truncating division.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_divide_64bit_signed_unsigned;

    import dv64_pkg::*;

    typedef struct {
        logic [63:0] dividend;
        logic [63:0] divisor;
        dv64_mode_t  mode;
    } div_op_t;

    typedef struct {
        logic [63:0] value;
        dv64_err_t   err;
    } div_res_t;

    localparam int unsigned RANDOM_OPS = 550;
    localparam int unsigned LATENCY    = 66;

    logic          aclk;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [127:0]  s_tdata  = '0;   // [63:0] dividend, [127:64] divisor
    logic [1:0]    s_tuser  = '0;   // [1:0] mode
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [63:0]   m_tdata;         // [63:0] result
    logic [1:0]    m_tuser;         // [1:0] error

    div_op_t       operand_q[$];
    div_res_t      div_results_q[$];

    bit            beat_done = 1'b0;
    int unsigned   gap_left = 0;
    int unsigned   burst_left = 1;
    int unsigned   rx_phase = 0;
    int unsigned   phase_left = 0;

    int unsigned   mismatch_cnt = 0;
    int unsigned   ops_taken = 0;
    int unsigned   results_seen = 0;
    int unsigned   zero_div_cnt = 0;
    int unsigned   overflow_cnt = 0;
    int unsigned   mode_cnt[4] = '{0, 0, 0, 0};

    divide_64bit_signed_unsigned dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #200000;
        $display("Timeout: %0d results still outstanding", div_results_q.size());
        $display("Mismatches found");
        $finish;
    end

    // truncating division on the raw bits; signed modes work on magnitudes
    function automatic div_res_t compute_division(input div_op_t op);
        div_res_t    r;
        logic [63:0] mag_n, mag_d, quo, rem;
        logic        neg_n, neg_d;
        r.value = '0;
        r.err   = ERR_OK;
        neg_n   = op.dividend[63];
        neg_d   = op.divisor[63];
        if (op.divisor == '0) begin
            r.err = ERR_DIV_ZERO;
        end else if (op.mode == MODE_UQUO) begin
            r.value = op.dividend / op.divisor;
        end else if (op.mode == MODE_UREM) begin
            r.value = op.dividend % op.divisor;
        end else if (op.mode == MODE_SQUO && op.dividend == MIN_S64 && op.divisor == NEG_ONE) begin
            r.err = ERR_OVERFLOW;
        end else begin
            mag_n = neg_n ? (64'd0 - op.dividend) : op.dividend;
            mag_d = neg_d ? (64'd0 - op.divisor) : op.divisor;
            quo   = mag_n / mag_d;
            rem   = mag_n % mag_d;
            if (op.mode == MODE_SQUO)
                r.value = (neg_n != neg_d) ? (64'd0 - quo) : quo;
            else
                r.value = neg_n ? (64'd0 - rem) : rem;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic add_op(input logic [63:0] a, input logic [63:0] b, input dv64_mode_t m);
        div_op_t op;
        op.dividend = a;
        op.divisor  = b;
        op.mode     = m;
        operand_q.push_back(op);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // mix of full-width, narrow, small, near-extreme and negative operands
    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = rand_word();
            4, 5:       v = rand_word() >> $urandom_range(0, 63);
            6:          v = 64'($urandom_range(0, 16));
            7:          v = 64'd0 - 64'($urandom_range(1, 16));
            8: begin
                case ($urandom_range(0, 5))
                    0:       v = MIN_S64;
                    1:       v = ~MIN_S64;
                    2:       v = NEG_ONE;
                    3:       v = '0;
                    4:       v = 64'd1;
                    default: v = MIN_S64 + 64'($urandom_range(1, 3));
                endcase
            end
            default:    v = ~(rand_word() >> $urandom_range(1, 63));
        endcase
        return v;
    endfunction

    task automatic add_random_ops(input int unsigned n);
        logic [63:0] a, b;
        repeat (n) begin
            if ($urandom_range(0, 49) == 0) begin
                a = MIN_S64;
                b = NEG_ONE;
            end else begin
                a = rand_operand();
                b = ($urandom_range(0, 29) == 0) ? '0 : rand_operand();
            end
            add_op(a, b, dv64_mode_t'($urandom_range(0, 3)));
        end
    endtask

    // hold until the input stream is empty and every result is back
    task automatic wait_drained();
        do @(negedge aclk);
        while (operand_q.size() != 0 || s_tvalid || div_results_q.size() != 0);
    endtask

    // input stream: bursts of random length separated by random gaps
    always @(negedge aclk) begin : drive_blk
        div_op_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || beat_done) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (operand_q.size() != 0) begin
                nxt = operand_q.pop_front();
                s_tdata  <= {nxt.divisor, nxt.dividend};
                s_tuser  <= nxt.mode;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                              : $urandom_range(0, 3);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output side: free-running, random, sparse and long-stall phases
    always @(negedge aclk) begin
        if (phase_left == 0) begin
            rx_phase   <= $urandom_range(0, 3);
            phase_left <= $urandom_range(8, 60);
        end else begin
            phase_left <= phase_left - 1;
        end
        case (rx_phase)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (phase_left % 4 == 0);
            default: m_tready <= (phase_left % 13 == 0);
        endcase
    end

    // check result beats first, then log the input beat taken at this edge
    always @(posedge aclk) begin : monitor_blk
        div_op_t  op;
        div_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (div_results_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h err %0d", m_tdata, m_tuser));
            end else begin
                want = div_results_q.pop_front();
                if (m_tdata !== want.value)
                    report_mismatch($sformatf("result %h, want %h", m_tdata, want.value));
                if (m_tuser !== want.err)
                    report_mismatch($sformatf("error %0d, want %0d", m_tuser, want.err));
            end
        end
        beat_done = aresetn && s_tvalid && s_tready;
        if (beat_done) begin
            op.dividend = s_tdata[63:0];
            op.divisor  = s_tdata[127:64];
            op.mode     = dv64_mode_t'(s_tuser);
            want = compute_division(op);
            div_results_q.push_back(want);
            ops_taken++;
            mode_cnt[s_tuser]++;
            if (want.err == ERR_DIV_ZERO) zero_div_cnt++;
            if (want.err == ERR_OVERFLOW) overflow_cnt++;
        end
    end

    initial begin
        @(posedge aresetn);

        // zero divisor in every mode
        add_op(64'd12345, '0, MODE_UQUO);
        add_op(NEG_ONE, '0, MODE_UREM);
        add_op(MIN_S64, '0, MODE_SQUO);
        add_op('0, '0, MODE_SREM);
        // minimum by -1: overflow for the signed quotient only
        add_op(MIN_S64, NEG_ONE, MODE_SQUO);
        add_op(MIN_S64, NEG_ONE, MODE_SREM);
        add_op(MIN_S64, NEG_ONE, MODE_UQUO);
        add_op(MIN_S64, NEG_ONE, MODE_UREM);
        // minimum magnitude wraps back to itself, then all-ones and zero-dividend edges
        add_op(MIN_S64, 64'd1, MODE_SQUO);
        add_op(MIN_S64, 64'd1, MODE_SREM);
        add_op(NEG_ONE, NEG_ONE, MODE_UQUO);
        add_op(NEG_ONE, NEG_ONE, MODE_UREM);
        add_op(NEG_ONE, 64'd1, MODE_UQUO);
        add_op('0, NEG_ONE, MODE_UQUO);
        add_op('0, NEG_ONE, MODE_UREM);
        add_op('0, NEG_ONE, MODE_SQUO);
        add_op('0, NEG_ONE, MODE_SREM);
        // sign mixes of 7 by 2, then minimum-value and unsigned remainder cases
        add_op(64'd7, 64'd0 - 64'd2, MODE_SQUO);
        add_op(64'd7, 64'd0 - 64'd2, MODE_SREM);
        add_op(64'd0 - 64'd7, 64'd2, MODE_SQUO);
        add_op(64'd0 - 64'd7, 64'd2, MODE_SREM);
        add_op(64'd0 - 64'd7, 64'd0 - 64'd2, MODE_SQUO);
        add_op(64'd0 - 64'd7, 64'd0 - 64'd2, MODE_SREM);
        add_op(MIN_S64, MIN_S64, MODE_SQUO);
        add_op(MIN_S64, ~MIN_S64, MODE_SREM);
        add_op(64'd5, NEG_ONE, MODE_UREM);

        // stop feeding until the directed set has fully drained
        wait_drained();
        add_random_ops(RANDOM_OPS / 2);
        wait_drained();
        add_random_ops(RANDOM_OPS - RANDOM_OPS / 2);
        wait_drained();
        repeat (LATENCY + 20) @(posedge aclk);

        if (div_results_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", div_results_q.size()));

        $display("Divided %0d operand pairs (modes %0d/%0d/%0d/%0d), checked %0d results",
                 ops_taken, mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3], results_seen);
        $display("Error cases seen: %0d zero divisor, %0d signed overflow",
                 zero_div_cnt, overflow_cnt);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
